FILE: sv/thsrag_pkg.sv
// shared types and constants for the transpose shard read address generator
package thsrag_pkg;

  localparam int STICK_W  = 24;
  localparam int CNT_W    = 12;
  localparam int SPS_W    = 16;
  localparam int OFF_W    = 32;
  localparam int GRID_W   = 5;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 16;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;
  localparam int DIVC_W   = 5;

  typedef enum logic [1:0] {
    REQ_MAP_X   = 2'd0,
    REQ_MAP_Y   = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_STEP    = 2'd3
  } req_kind_t;

  localparam logic [CIDX_W-1:0] CFG_STICKS_PER_SHARD = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_CHANNELS         = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT           = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_STICK_BYTES      = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_GRID_ROW_MAJOR   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_GRID_COLS        = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_GRID_ROWS        = 3'd6;

  typedef struct packed {
    logic [SPS_W-1:0]   sticks_per_shard;
    logic [CNT_W-1:0]   channels;
    logic [CNT_W-1:0]   height;
    logic [SPS_W-1:0]   stick_bytes;
    logic               grid_row_major;
    logic [GRID_W-1:0]  grid_cols;
    logic [GRID_W-1:0]  grid_rows;
  } cfg_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [3:0]         map_index;
    logic [7:0]         map_coord;
    logic [STICK_W-1:0] stick;
    logic [OFF_W-1:0]   dest;
    logic               last;
  } job_t;

endpackage

FILE: sv/thsrag_ifs.sv
// request, response and register write channel interfaces
interface thsrag_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  map_index;
  logic [7:0]  map_coord;
  logic [23:0] begin_stick;
  logic [11:0] begin_chan;
  logic [11:0] begin_row;
  modport source (output valid, req_type, map_index, map_coord, begin_stick, begin_chan,
                  begin_row, input ready);
  modport sink (input valid, req_type, map_index, map_coord, begin_stick, begin_chan,
                begin_row, output ready);
endinterface

interface thsrag_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  core_x;
  logic [7:0]  core_y;
  logic [31:0] src_offset;
  logic [31:0] dst_offset;
  logic        grid_error;
  logic        last;
  modport source (output valid, core_x, core_y, src_offset, dst_offset, grid_error, last,
                  input ready);
  modport sink (input valid, core_x, core_y, src_offset, dst_offset, grid_error, last,
                output ready);
endinterface

interface thsrag_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/transpose_hc_shard_read_address_gen.sv
// top level of the transpose shard read descriptor generator
//
//   channel | dir | payload                                         | taken when
//   req     | in  | req_type map_index map_coord begin_*            | valid && ready
//   rsp     | out | core_x core_y src_offset dst_offset grid_error last | valid && ready
//   cfg     | in  | index data                                      | valid (ready held high)
//
// restarts act in the front end at once; map writes are queued and written when the back end pops them.
// a step holds the back end from pop to next pop: the shard and grid splits run in turn
// on the shared one-bit-per-cycle divider, then table read, output load and idle.
// reset restores register defaults and clears counters and queue; tables keep old contents.
// requests are taken while the four-entry queue has room; a stalled response holds the back end.
module transpose_hc_shard_read_address_gen #(
  parameter int MAP_DEPTH  = 16,
  parameter int COORD_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  thsrag_in_if.sink    req,
  thsrag_out_if.source rsp,
  thsrag_cfg_if.sink   cfg
);

  thsrag_pkg::cfg_t cfg_q;
  thsrag_pkg::job_t push_job;
  thsrag_pkg::job_t q_job;
  logic             push;
  logic             q_ready;
  logic             q_valid;
  logic             pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.sticks_per_shard <= 16'd1;
      cfg_q.channels         <= 12'd1;
      cfg_q.height           <= 12'd1;
      cfg_q.stick_bytes      <= 16'd2;
      cfg_q.grid_row_major   <= 1'b1;
      cfg_q.grid_cols        <= 5'd1;
      cfg_q.grid_rows        <= 5'd1;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          thsrag_pkg::CFG_STICKS_PER_SHARD: cfg_q.sticks_per_shard <= cfg.data;
          thsrag_pkg::CFG_CHANNELS:         cfg_q.channels         <= cfg.data[11:0];
          thsrag_pkg::CFG_HEIGHT:           cfg_q.height           <= cfg.data[11:0];
          thsrag_pkg::CFG_STICK_BYTES:      cfg_q.stick_bytes      <= cfg.data;
          thsrag_pkg::CFG_GRID_ROW_MAJOR:   cfg_q.grid_row_major   <= cfg.data[0];
          thsrag_pkg::CFG_GRID_COLS:        cfg_q.grid_cols        <= cfg.data[4:0];
          thsrag_pkg::CFG_GRID_ROWS:        cfg_q.grid_rows        <= cfg.data[4:0];
          default: begin
            cfg_q.grid_rows <= cfg_q.grid_rows;
          end
        endcase
      end
    end
  end

  thsrag_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg_q),
    .q_ready (q_ready),
    .push    (push),
    .job     (push_job)
  );

  thsrag_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .in_ready  (q_ready),
    .pop       (pop),
    .out_valid (q_valid),
    .out_job   (q_job)
  );

  thsrag_back #(.MAP_DEPTH(MAP_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_q),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

FILE: sv/thsrag_ram.sv
// generic single write port ram with registered read
module thsrag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/thsrag_front.sv
// front end: takes requests, keeps the stick and counter state, queues jobs
module thsrag_front (
  input  logic                clk,
  input  logic                rst,
  thsrag_in_if.sink           req,
  input  thsrag_pkg::cfg_t    cfg,
  input  logic                q_ready,
  output logic                push,
  output thsrag_pkg::job_t    job
);

  logic [thsrag_pkg::STICK_W-1:0] stick_pos, stick_pos_next;
  logic [thsrag_pkg::CNT_W-1:0]   chan_count, chan_count_next;
  logic [thsrag_pkg::CNT_W-1:0]   row_count, row_count_next;
  logic [thsrag_pkg::SPS_W-1:0]   emitted, emitted_next;
  logic [thsrag_pkg::OFF_W-1:0]   dest_pos, dest_pos_next;

  logic                           accept;
  logic                           live;
  logic [thsrag_pkg::SPS_W:0]     emitted_inc;
  logic [thsrag_pkg::CNT_W-1:0]   chan_inc;
  logic [thsrag_pkg::CNT_W-1:0]   row_inc;
  logic [thsrag_pkg::STICK_W-1:0] plane;
  thsrag_pkg::req_kind_t          kind;

  assign req.ready   = q_ready;
  assign accept      = req.valid && req.ready;
  assign kind        = thsrag_pkg::req_kind_t'(req.req_type);
  assign live        = emitted < cfg.sticks_per_shard;
  assign emitted_inc = {1'b0, emitted} + 17'd1;
  assign chan_inc    = chan_count + 12'd1;
  assign row_inc     = row_count + 12'd1;
  assign plane       = thsrag_pkg::STICK_W'(cfg.channels) * thsrag_pkg::STICK_W'(cfg.height);

  always_comb begin
    push            = 1'b0;
    stick_pos_next  = stick_pos;
    chan_count_next = chan_count;
    row_count_next  = row_count;
    emitted_next    = emitted;
    dest_pos_next   = dest_pos;
    if (accept) begin
      case (kind)
        thsrag_pkg::REQ_MAP_X, thsrag_pkg::REQ_MAP_Y: begin
          push = 1'b1;
        end
        thsrag_pkg::REQ_RESTART: begin
          stick_pos_next  = req.begin_stick;
          chan_count_next = req.begin_chan;
          row_count_next  = req.begin_row;
          emitted_next    = '0;
          dest_pos_next   = '0;
        end
        thsrag_pkg::REQ_STEP: begin
          if (live) begin
            push          = 1'b1;
            emitted_next  = emitted_inc[thsrag_pkg::SPS_W-1:0];
            dest_pos_next = dest_pos + 32'(cfg.stick_bytes);
            if (chan_inc == cfg.channels) begin
              chan_count_next = '0;
              if (row_inc == cfg.height) begin
                row_count_next = '0;
                stick_pos_next = stick_pos + 24'd1;
              end else begin
                row_count_next = row_inc;
                // back to the next channel-0 stick of the following row
                stick_pos_next = stick_pos + 24'(cfg.height) + 24'd1 - plane;
              end
            end else begin
              chan_count_next = chan_inc;
              stick_pos_next  = stick_pos + 24'(cfg.height);
            end
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    job.kind      = kind;
    job.map_index = req.map_index;
    job.map_coord = req.map_coord;
    job.stick     = stick_pos;
    job.dest      = dest_pos;
    job.last      = emitted_inc == {1'b0, cfg.sticks_per_shard};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_pos  <= '0;
      chan_count <= '0;
      row_count  <= '0;
      emitted    <= '0;
      dest_pos   <= '0;
    end else begin
      stick_pos  <= stick_pos_next;
      chan_count <= chan_count_next;
      row_count  <= row_count_next;
      emitted    <= emitted_next;
      dest_pos   <= dest_pos_next;
    end
  end

endmodule

FILE: sv/thsrag_queue.sv
// short job queue between front and back
module thsrag_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  thsrag_pkg::job_t push_job,
  output logic             in_ready,
  input  logic             pop,
  output logic             out_valid,
  output thsrag_pkg::job_t out_job
);

  thsrag_pkg::job_t                  slots [thsrag_pkg::QDEPTH];
  logic [thsrag_pkg::QPTR_W-1:0]     wptr;
  logic [thsrag_pkg::QPTR_W-1:0]     rptr;
  logic [thsrag_pkg::QCNT_W-1:0]     count;

  assign in_ready  = count != thsrag_pkg::QCNT_W'(thsrag_pkg::QDEPTH);
  assign out_valid = count != '0;
  assign out_job   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + thsrag_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + thsrag_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + thsrag_pkg::QCNT_W'(1);
        2'b01:   count <= count - thsrag_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= thsrag_pkg::QCNT_W'(thsrag_pkg::QDEPTH))
    else $error("job queue holds more than its depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("job queue popped while empty");

endmodule

FILE: sv/thsrag_div.sv
// restoring divider, one quotient bit per cycle
module thsrag_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [thsrag_pkg::STICK_W-1:0]    dividend,
  input  logic [thsrag_pkg::SPS_W-1:0]      divisor,
  output logic                              done,
  output logic [thsrag_pkg::STICK_W-1:0]    quot,
  output logic [thsrag_pkg::SPS_W-1:0]      rem
);

  logic                             busy;
  logic [thsrag_pkg::DIVC_W-1:0]    cnt;
  logic [thsrag_pkg::SPS_W-1:0]     d;
  logic [thsrag_pkg::SPS_W:0]       shifted;
  logic [thsrag_pkg::SPS_W:0]       diff;
  logic                             ge;

  assign shifted = {rem, quot[thsrag_pkg::STICK_W-1]};
  assign ge      = shifted >= {1'b0, d};
  assign diff    = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + thsrag_pkg::DIVC_W'(1);
        if (cnt == thsrag_pkg::DIVC_W'(thsrag_pkg::STICK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      d    <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[thsrag_pkg::SPS_W-1:0] : shifted[thsrag_pkg::SPS_W-1:0];
      quot <= {quot[thsrag_pkg::STICK_W-2:0], ge};
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

FILE: sv/thsrag_back.sv
// back end: map table writes, shard and grid division, descriptor output
module thsrag_back #(
  parameter int MAP_DEPTH  = 16,
  parameter int COORD_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  thsrag_pkg::cfg_t cfg,
  input  logic             q_valid,
  input  thsrag_pkg::job_t q_job,
  output logic             pop,
  thsrag_out_if.source     rsp
);

  localparam int AW = MAP_DEPTH > 1 ? $clog2(MAP_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_READ,
    S_DONE
  } state_t;

  state_t                            state;
  logic [thsrag_pkg::OFF_W-1:0]      dest;
  logic                              last;
  logic [thsrag_pkg::SPS_W-1:0]      in_shard;
  logic [thsrag_pkg::OFF_W-1:0]      src_off;
  logic                              err;
  logic [AW-1:0]                     xa;
  logic [AW-1:0]                     ya;

  logic                              out_valid;
  logic [7:0]                        out_x;
  logic [7:0]                        out_y;
  logic [thsrag_pkg::OFF_W-1:0]      out_src;
  logic [thsrag_pkg::OFF_W-1:0]      out_dst;
  logic                              out_err;
  logic                              out_last;

  logic                              div_start;
  logic [thsrag_pkg::STICK_W-1:0]    div_dividend;
  logic [thsrag_pkg::SPS_W-1:0]      div_divisor;
  logic                              div_done;
  logic [thsrag_pkg::STICK_W-1:0]    div_quot;
  logic [thsrag_pkg::SPS_W-1:0]      div_rem;

  logic [thsrag_pkg::GRID_W-1:0]     inner_dim;
  logic [thsrag_pkg::GRID_W-1:0]     outer_dim;
  logic [thsrag_pkg::GRID_W-1:0]     inner_div;
  logic [thsrag_pkg::GRID_W-1:0]     inner;
  logic [thsrag_pkg::STICK_W-1:0]    xi;
  logic [thsrag_pkg::STICK_W-1:0]    yi;
  logic                              err_next;

  logic                              is_map;
  logic                              x_we;
  logic                              y_we;
  logic [AW-1:0]                     waddr;
  logic [COORD_BITS-1:0]             wdata;
  logic [COORD_BITS-1:0]             x_rdata;
  logic [COORD_BITS-1:0]             y_rdata;
  logic                              out_free;

  assign pop      = (state == S_IDLE) && q_valid;
  assign is_map   = (q_job.kind == thsrag_pkg::REQ_MAP_X) || (q_job.kind == thsrag_pkg::REQ_MAP_Y);
  assign out_free = !out_valid || rsp.ready;

  // writes past the table are dropped
  assign x_we  = pop && (q_job.kind == thsrag_pkg::REQ_MAP_X)
                 && (32'(q_job.map_index) < 32'(MAP_DEPTH));
  assign y_we  = pop && (q_job.kind == thsrag_pkg::REQ_MAP_Y)
                 && (32'(q_job.map_index) < 32'(MAP_DEPTH));
  assign waddr = AW'(q_job.map_index);
  assign wdata = COORD_BITS'(q_job.map_coord);

  assign inner_dim = cfg.grid_row_major ? cfg.grid_cols : cfg.grid_rows;
  assign outer_dim = cfg.grid_row_major ? cfg.grid_rows : cfg.grid_cols;
  assign inner_div = (inner_dim == '0) ? 5'd1 : inner_dim;

  // one divider serves both the shard split and the grid split
  always_comb begin
    div_start    = 1'b0;
    div_dividend = q_job.stick;
    div_divisor  = cfg.sticks_per_shard;
    if (pop && (q_job.kind == thsrag_pkg::REQ_STEP)) begin
      div_start = 1'b1;
    end else if ((state == S_DIV1) && div_done) begin
      div_start    = 1'b1;
      div_dividend = div_quot;
      div_divisor  = 16'(inner_div);
    end
  end

  assign inner    = div_rem[thsrag_pkg::GRID_W-1:0];
  assign xi       = cfg.grid_row_major ? 24'(inner) : div_quot;
  assign yi       = cfg.grid_row_major ? div_quot : 24'(inner);
  assign err_next = (div_quot >= 24'(outer_dim)) || (32'(xi) >= 32'(MAP_DEPTH))
                    || (32'(yi) >= 32'(MAP_DEPTH));

  thsrag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  thsrag_ram #(.WIDTH(COORD_BITS), .DEPTH(MAP_DEPTH)) u_x_table (
    .clk   (clk),
    .we    (x_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (xa),
    .rdata (x_rdata)
  );

  thsrag_ram #(.WIDTH(COORD_BITS), .DEPTH(MAP_DEPTH)) u_y_table (
    .clk   (clk),
    .we    (y_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ya),
    .rdata (y_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      xa        <= '0;
      ya        <= '0;
    end else begin
      // the output state reloads the register itself
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop && !is_map) begin
            dest  <= q_job.dest;
            last  <= q_job.last;
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            in_shard <= div_rem;
            state    <= S_DIV2;
          end
        end
        S_DIV2: begin
          src_off <= 32'(in_shard) * 32'(cfg.stick_bytes);
          if (div_done) begin
            err   <= err_next;
            xa    <= AW'(xi);
            ya    <= AW'(yi);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_x     <= err ? 8'd0 : 8'(x_rdata);
            out_y     <= err ? 8'd0 : 8'(y_rdata);
            out_src   <= src_off;
            out_dst   <= dest;
            out_err   <= err;
            out_last  <= last;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.core_x     = out_x;
  assign rsp.core_y     = out_y;
  assign rsp.src_offset = out_src;
  assign rsp.dst_offset = out_dst;
  assign rsp.grid_error = out_err;
  assign rsp.last       = out_last;

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("descriptor loaded outside the output state");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == S_IDLE) || (state == S_DIV1))
    else $error("division started in the wrong phase");

endmodule

FILE: tb/transpose_hc_shard_read_address_gen_test.sv
// self-checking testbench for the transpose shard read descriptor generator
module transpose_hc_shard_read_address_gen_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_ENTRIES   = 16;
  localparam int IDLE_MAX      = 17;
  localparam int DRAIN_CYCLES  = 320;
  localparam int RANDOM_TOTAL  = 600;
  localparam int RANDOM_PHASES = 8;
  localparam int RUN_CAP       = 12;
  // index with no register behind it
  localparam logic [thsrag_pkg::CIDX_W-1:0] CFG_NONE = 3'd7;

  typedef struct packed {
    thsrag_pkg::req_kind_t          kind;
    logic [3:0]                     map_index;
    logic [7:0]                     map_coord;
    logic [thsrag_pkg::STICK_W-1:0] begin_stick;
    logic [thsrag_pkg::CNT_W-1:0]   begin_chan;
    logic [thsrag_pkg::CNT_W-1:0]   begin_row;
  } request_t;

  typedef struct packed {
    logic [7:0]                   core_x;
    logic [7:0]                   core_y;
    logic [thsrag_pkg::OFF_W-1:0] src_offset;
    logic [thsrag_pkg::OFF_W-1:0] dst_offset;
    logic                         grid_error;
    logic                         last;
  } descriptor_t;

  typedef struct packed {
    logic [thsrag_pkg::SPS_W-1:0]  sticks_per_shard;
    logic [thsrag_pkg::CNT_W-1:0]  channels;
    logic [thsrag_pkg::CNT_W-1:0]  height;
    logic [thsrag_pkg::SPS_W-1:0]  stick_bytes;
    logic                          grid_row_major;
    logic [thsrag_pkg::GRID_W-1:0] grid_cols;
    logic [thsrag_pkg::GRID_W-1:0] grid_rows;
  } setting_t;

  logic clk = 1'b0;
  logic rst;

  thsrag_in_if  req_if ();
  thsrag_out_if rsp_if ();
  thsrag_cfg_if cfg_if ();

  transpose_hc_shard_read_address_gen DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // generator state as the block should hold it
  setting_t                       gen_setting;
  logic [thsrag_pkg::STICK_W-1:0] next_stick;
  logic [thsrag_pkg::CNT_W-1:0]   chan_ctr;
  logic [thsrag_pkg::CNT_W-1:0]   row_ctr;
  logic [thsrag_pkg::SPS_W-1:0]   run_done;
  logic [thsrag_pkg::OFF_W-1:0]   dest_ptr;
  logic [7:0]                     x_coord_map [MAP_ENTRIES];
  logic [7:0]                     y_coord_map [MAP_ENTRIES];

  descriptor_t expected_descriptors[$];
  bit          no_idle = 1'b0;
  int          mismatch_count = 0;
  int          descriptors_checked = 0;
  int          requests_sent = 0;
  int          effective_requests = 0;
  int          idle_steps = 0;
  int          settings_used = 0;

  function automatic bit advance_generator(input request_t r, output descriptor_t d);
    int unsigned shard, in_shard, inner_dim, outer_dim, divisor, outer, inner, xi, yi;
    logic [thsrag_pkg::STICK_W-1:0] plane;
    bit err;
    d = '0;
    case (r.kind)
      thsrag_pkg::REQ_MAP_X: x_coord_map[r.map_index] = r.map_coord;
      thsrag_pkg::REQ_MAP_Y: y_coord_map[r.map_index] = r.map_coord;
      thsrag_pkg::REQ_RESTART: begin
        next_stick = r.begin_stick;
        chan_ctr   = r.begin_chan;
        row_ctr    = r.begin_row;
        run_done   = '0;
        dest_ptr   = '0;
      end
      default: ;
    endcase
    if (r.kind != thsrag_pkg::REQ_STEP || run_done >= gen_setting.sticks_per_shard)
      return 1'b0;

    shard     = next_stick / gen_setting.sticks_per_shard;
    in_shard  = next_stick - shard * gen_setting.sticks_per_shard;
    inner_dim = gen_setting.grid_row_major ? gen_setting.grid_cols : gen_setting.grid_rows;
    outer_dim = gen_setting.grid_row_major ? gen_setting.grid_rows : gen_setting.grid_cols;
    divisor   = (inner_dim != 0) ? inner_dim : 1;
    outer     = shard / divisor;
    inner     = shard - outer * divisor;
    xi        = gen_setting.grid_row_major ? inner : outer;
    yi        = gen_setting.grid_row_major ? outer : inner;
    err       = (outer >= outer_dim) || (xi >= MAP_ENTRIES) || (yi >= MAP_ENTRIES);
    if (!err) begin
      d.core_x = x_coord_map[xi];
      d.core_y = y_coord_map[yi];
    end
    d.src_offset = in_shard * gen_setting.stick_bytes;
    d.dst_offset = dest_ptr;
    d.grid_error = err;
    d.last       = (run_done + 16'd1 == gen_setting.sticks_per_shard);

    dest_ptr   = dest_ptr + gen_setting.stick_bytes;
    run_done   = run_done + 1'b1;
    chan_ctr   = chan_ctr + 1'b1;
    next_stick = next_stick + gen_setting.height;
    // counters roll only on an exact match with the size
    if (chan_ctr == gen_setting.channels) begin
      chan_ctr = '0;
      row_ctr  = row_ctr + 1'b1;
      if (row_ctr == gen_setting.height) begin
        row_ctr    = '0;
        next_stick = next_stick - gen_setting.height + 1'b1;
      end else begin
        plane      = thsrag_pkg::STICK_W'(gen_setting.channels) *
                     thsrag_pkg::STICK_W'(gen_setting.height);
        next_stick = next_stick - plane + 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic request_t random_request(input thsrag_pkg::req_kind_t kind);
    request_t r;
    r.kind        = kind;
    r.map_index   = 4'($urandom);
    r.map_coord   = 8'($urandom);
    r.begin_stick = thsrag_pkg::STICK_W'($urandom);
    r.begin_chan  = thsrag_pkg::CNT_W'($urandom);
    r.begin_row   = thsrag_pkg::CNT_W'($urandom);
    return r;
  endfunction

  task automatic send_request(input request_t r);
    int unsigned gap;
    descriptor_t d;
    gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.kind;
    req_if.map_index   <= r.map_index;
    req_if.map_coord   <= r.map_coord;
    req_if.begin_stick <= r.begin_stick;
    req_if.begin_chan  <= r.begin_chan;
    req_if.begin_row   <= r.begin_row;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    requests_sent++;
    if (advance_generator(r, d)) begin
      expected_descriptors = {expected_descriptors, d};
      effective_requests++;
    end else if (r.kind == thsrag_pkg::REQ_STEP) begin
      idle_steps++;
    end else begin
      effective_requests++;
    end
  endtask

  // steps past the end of a run give nothing back, so wait out the queue as well
  task automatic settle();
    req_if.valid <= 1'b0;
    while (expected_descriptors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [thsrag_pkg::CIDX_W-1:0] index,
                                input logic [thsrag_pkg::CDATA_W-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    case (index)
      thsrag_pkg::CFG_STICKS_PER_SHARD: gen_setting.sticks_per_shard = data;
      thsrag_pkg::CFG_CHANNELS:       gen_setting.channels = data[thsrag_pkg::CNT_W-1:0];
      thsrag_pkg::CFG_HEIGHT:         gen_setting.height = data[thsrag_pkg::CNT_W-1:0];
      thsrag_pkg::CFG_STICK_BYTES:    gen_setting.stick_bytes = data;
      thsrag_pkg::CFG_GRID_ROW_MAJOR: gen_setting.grid_row_major = data[0];
      thsrag_pkg::CFG_GRID_COLS:      gen_setting.grid_cols = data[thsrag_pkg::GRID_W-1:0];
      thsrag_pkg::CFG_GRID_ROWS:      gen_setting.grid_rows = data[thsrag_pkg::GRID_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise that the block must drop
  task automatic apply_setting(input setting_t s);
    settle();
    write_register(thsrag_pkg::CFG_STICKS_PER_SHARD, s.sticks_per_shard);
    write_register(thsrag_pkg::CFG_CHANNELS, {4'($urandom), s.channels});
    write_register(thsrag_pkg::CFG_HEIGHT, {4'($urandom), s.height});
    write_register(thsrag_pkg::CFG_STICK_BYTES, s.stick_bytes);
    write_register(thsrag_pkg::CFG_GRID_ROW_MAJOR, {15'($urandom), s.grid_row_major});
    write_register(thsrag_pkg::CFG_GRID_COLS, {11'($urandom), s.grid_cols});
    write_register(thsrag_pkg::CFG_GRID_ROWS, {11'($urandom), s.grid_rows});
    write_register(CFG_NONE, 16'($urandom));
    settings_used++;
  endtask

  function automatic setting_t random_setting();
    setting_t s;
    s.sticks_per_shard = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
    s.channels         = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(1, 5));
    s.height           = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(1, 5));
    s.stick_bytes      = 16'($urandom);
    s.grid_row_major   = 1'($urandom);
    s.grid_cols        = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    s.grid_rows        = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    return s;
  endfunction

  task automatic note_mismatch(input string what, input descriptor_t want, input descriptor_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: expected x=%0d y=%0d src=%h dst=%h err=%b last=%b",
               $time, what, want.core_x, want.core_y, want.src_offset, want.dst_offset,
               want.grid_error, want.last);
      $display("[%0t] %s: actual   x=%0d y=%0d src=%h dst=%h err=%b last=%b",
               $time, what, got.core_x, got.core_y, got.src_offset, got.dst_offset,
               got.grid_error, got.last);
    end
  endtask

  // response side stall, drawn anew for every descriptor
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    descriptor_t got, want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = '{rsp_if.core_x, rsp_if.core_y, rsp_if.src_offset, rsp_if.dst_offset,
              rsp_if.grid_error, rsp_if.last};
      if (expected_descriptors.size() == 0) begin
        note_mismatch("descriptor with no request behind it", '0, got);
      end else begin
        want = expected_descriptors.pop_front();
        descriptors_checked++;
        if (got.core_x !== want.core_x || got.core_y !== want.core_y ||
            got.src_offset !== want.src_offset || got.dst_offset !== want.dst_offset ||
            got.grid_error !== want.grid_error || got.last !== want.last)
          note_mismatch("descriptor mismatch", want, got);
      end
    end
  end

  // every table entry gets written before any lookup can reach it
  task automatic fill_core_maps();
    request_t r;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      r = random_request(thsrag_pkg::REQ_MAP_X);
      r.map_index = 4'(i);
      send_request(r);
      r.kind = thsrag_pkg::REQ_MAP_Y;
      r.map_coord = 8'($urandom);
      send_request(r);
    end
  endtask

  task automatic test_reset_defaults();
    request_t r;
    // one-stick run straight out of reset, then a step past its end
    send_request(random_request(thsrag_pkg::REQ_STEP));
    send_request(random_request(thsrag_pkg::REQ_STEP));
    r = random_request(thsrag_pkg::REQ_RESTART);
    r.begin_stick = '0;
    r.begin_chan  = '0;
    r.begin_row   = '0;
    send_request(r);
    send_request(random_request(thsrag_pkg::REQ_STEP));
  endtask

  task automatic test_counter_extremes();
    request_t r;
    apply_setting('{16'd4, 12'd3, 12'd2, 16'hFFFF, 1'b1, 5'd4, 5'd4});
    // top stick lands far outside the grid, counters start past their sizes
    r = random_request(thsrag_pkg::REQ_RESTART);
    r.begin_stick = '1;
    r.begin_chan  = '1;
    r.begin_row   = '1;
    send_request(r);
    repeat (5) send_request(random_request(thsrag_pkg::REQ_STEP));
    r.begin_stick = 24'd5;
    r.begin_chan  = 12'd2;
    r.begin_row   = 12'd1;
    send_request(r);
    repeat (2) send_request(random_request(thsrag_pkg::REQ_STEP));
  endtask

  task automatic test_grid_orders();
    request_t r;
    apply_setting('{16'd2, 12'd1, 12'd1, 16'd1, 1'b0, 5'd3, 5'd16});
    r = random_request(thsrag_pkg::REQ_MAP_X);
    r.map_index = 4'd0;
    r.map_coord = 8'd0;
    send_request(r);
    r.kind      = thsrag_pkg::REQ_MAP_Y;
    r.map_index = 4'd15;
    r.map_coord = 8'hFF;
    send_request(r);
    // column-major: shard 15 reads the last y entry
    r = random_request(thsrag_pkg::REQ_RESTART);
    r.begin_stick = 24'd30;
    send_request(r);
    repeat (2) send_request(random_request(thsrag_pkg::REQ_STEP));
    // outer index equal to grid_cols
    r.begin_stick = 24'd96;
    send_request(r);
    send_request(random_request(thsrag_pkg::REQ_STEP));
  endtask

  task automatic test_degenerate_sizes();
    request_t r;
    apply_setting('{16'd2, 12'd1, 12'd1, 16'd1, 1'b0, 5'd3, 5'd0});
    r = random_request(thsrag_pkg::REQ_RESTART);
    r.begin_stick = 24'd4;
    send_request(r);
    repeat (2) send_request(random_request(thsrag_pkg::REQ_STEP));
    // empty runs: steps give nothing
    apply_setting('{16'd0, 12'd1, 12'd1, 16'd1, 1'b1, 5'd1, 5'd1});
    send_request(random_request(thsrag_pkg::REQ_RESTART));
    repeat (2) send_request(random_request(thsrag_pkg::REQ_STEP));
  endtask

  task automatic run_sequence();
    request_t r;
    int unsigned shards, sps, steps, ch, ht;
    sps = gen_setting.sticks_per_shard;
    if ($urandom_range(0, 9) < 8) begin
      shards = gen_setting.grid_cols * gen_setting.grid_rows;
      ch = gen_setting.channels;
      ht = gen_setting.height;
      r = random_request(thsrag_pkg::REQ_RESTART);
      r.begin_stick = thsrag_pkg::STICK_W'($urandom_range(0, shards) * sps +
                                           ((sps != 0) ? $urandom_range(0, sps - 1) : 0));
      if ($urandom_range(0, 3) != 0) begin
        r.begin_chan = (ch != 0) ? thsrag_pkg::CNT_W'($urandom_range(0, ch - 1)) : '0;
        r.begin_row  = (ht != 0) ? thsrag_pkg::CNT_W'($urandom_range(0, ht - 1)) : '0;
      end
      send_request(r);
      steps = ((sps < RUN_CAP) ? sps : RUN_CAP) + $urandom_range(0, 1);
      for (int i = 0; i < steps; i++) begin
        // occasional table update in the middle of a run
        if ($urandom_range(0, 15) == 0)
          send_request(random_request($urandom_range(0, 1) ? thsrag_pkg::REQ_MAP_X
                                                           : thsrag_pkg::REQ_MAP_Y));
        send_request(random_request(thsrag_pkg::REQ_STEP));
      end
    end else begin
      send_request(random_request(thsrag_pkg::req_kind_t'(2'($urandom))));
    end
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        apply_setting('{16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1, 5'd16, 5'd16});
      else if (phase == 1)
        apply_setting('{16'd1, 12'd1, 12'd1, 16'd0, 1'b0, 5'd1, 5'd1});
      else
        apply_setting(random_setting());
      no_idle = (phase == 3 || phase == 6);
      target = effective_requests + RANDOM_TOTAL / RANDOM_PHASES;
      while (effective_requests < target) run_sequence();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= thsrag_pkg::REQ_MAP_X;
    req_if.map_index   <= '0;
    req_if.map_coord   <= '0;
    req_if.begin_stick <= '0;
    req_if.begin_chan  <= '0;
    req_if.begin_row   <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= thsrag_pkg::CFG_STICKS_PER_SHARD;
    cfg_if.data        <= '0;
    gen_setting = '{16'd1, 12'd1, 12'd1, 16'd2, 1'b1, 5'd1, 5'd1};
    next_stick  = '0;
    chan_ctr    = '0;
    row_ctr     = '0;
    run_done    = '0;
    dest_ptr    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    fill_core_maps();
    test_reset_defaults();
    test_counter_extremes();
    test_grid_orders();
    test_degenerate_sizes();
    test_random_traffic();
    settle();

    $display("%0d requests over %0d register settings, %0d descriptors checked",
             requests_sent, settings_used, descriptors_checked);
    $display("%0d steps fell past the end of a run, %0d mismatches", idle_steps, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
